// ----- hdl/median3_ema_loadcell_filter_defines.svh -----
// Assertion macros used by the checker file mcf_checker.sv.
`ifndef MEDIAN3_EMA_LOADCELL_FILTER_DEFINES_SVH
`define MEDIAN3_EMA_LOADCELL_FILTER_DEFINES_SVH

// Checked only out of reset.
`define MCF_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define MCF_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/mcf_pkg.sv -----
`default_nettype none
package mcf_pkg;

  localparam int SAMPLE_W = 24;
  localparam int ALPHA_W  = 16;
  localparam int FRAC_W   = 16;
  localparam int AVG_W    = SAMPLE_W + FRAC_W;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd13107;  // 0.2 in Q0.16

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [AVG_W-1:0]    avg_t;

endpackage
`default_nettype wire

// ----- hdl/median3_ema_loadcell_filter.sv -----
`default_nettype none
// Median-of-three load-cell filter with an exponential moving average. Each transaction carries
// three signed 24-bit samples and a converter ready flag; when the flag is set the median (in
// offset binary) updates a Q24.16 average, the first such transaction loading it directly, and
// every transaction returns the integer part of the average with sensor_ok equal to the flag.
// The block takes one transaction per clock cycle unless out_ready stalls it; a result passes
// the input register, then the result register. The average update, median select plus a 17x25
// and a 16x16 multiply and a 43-bit add, sits between them and closes its loop through avg_r. The
// user writes alpha via cfg_we/cfg_wdata only while the block is idle, unenforced. Reset is 0.2.
module median3_ema_loadcell_filter (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire [mcf_pkg::ALPHA_W-1:0]  cfg_wdata,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire signed [mcf_pkg::SAMPLE_W-1:0] in_sample_a,
  input  wire signed [mcf_pkg::SAMPLE_W-1:0] in_sample_b,
  input  wire signed [mcf_pkg::SAMPLE_W-1:0] in_sample_c,
  input  wire                         in_converter_ready,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [mcf_pkg::SAMPLE_W-1:0] out_filtered_value,
  output logic                        out_sensor_ok
);

  localparam int SW = mcf_pkg::SAMPLE_W;
  localparam int FW = mcf_pkg::FRAC_W;
  localparam int AW = mcf_pkg::ALPHA_W;
  localparam int VW = mcf_pkg::AVG_W;

  // input stage
  logic                     s1_valid_r, s1_valid_nxt;
  logic [SW-1:0]            s1_a_r, s1_b_r, s1_c_r;
  logic                     s1_rdy_r;
  // result stage
  logic                     out_valid_r, out_valid_nxt;
  mcf_pkg::sample_t         out_value_r, out_value_nxt;
  logic                     out_ok_r, out_ok_nxt;
  // state
  logic [AW-1:0]            alpha_r, alpha_nxt;
  mcf_pkg::avg_t            avg_r, avg_nxt;
  logic                     primed_r, primed_nxt;

  logic                     out_take, s1_move;
  mcf_pkg::sample_t         oa, ob, oc, med;
  logic signed [SW:0]       diff;
  logic signed [SW+AW+1:0]  prod_hi;
  logic [2*AW-1:0]          prod_lo;
  logic [2*AW:0]            prod_lo_rnd;
  logic [AW:0]              corr;
  logic signed [VW+2:0]     upd;
  mcf_pkg::avg_t            avg_upd;

  always_comb begin
    out_take = !out_valid_r || out_ready;
    s1_move  = s1_valid_r && out_take;
    in_ready = !s1_valid_r || out_take;

    // offset binary keeps signed order
    oa = {~s1_a_r[SW-1], s1_a_r[SW-2:0]};
    ob = {~s1_b_r[SW-1], s1_b_r[SW-2:0]};
    oc = {~s1_c_r[SW-1], s1_c_r[SW-2:0]};
    if (oa > ob) begin
      if (ob > oc)      med = ob;
      else if (oa > oc) med = oc;
      else              med = oa;
    end else begin
      if (oa > oc)      med = oa;
      else if (ob > oc) med = oc;
      else              med = ob;
    end

    // avg + floor(alpha*(X - avg) / 2^16), split into integer and fraction parts:
    // alpha*(x - int) - ceil(alpha*frac / 2^16)
    diff        = $signed({1'b0, med}) - $signed({1'b0, avg_r[VW-1:FW]});
    prod_hi     = $signed({1'b0, alpha_r}) * diff;
    prod_lo     = alpha_r * avg_r[FW-1:0];
    prod_lo_rnd = {1'b0, prod_lo} + {{(AW+1){1'b0}}, {FW{1'b1}}};
    corr        = prod_lo_rnd[2*AW:FW];
    upd         = $signed({3'b000, avg_r}) + $signed({prod_hi[SW+AW+1], prod_hi})
                  - $signed({{(VW+2-AW){1'b0}}, corr});
    avg_upd     = upd[VW-1:0];

    alpha_nxt     = cfg_we ? cfg_wdata : alpha_r;
    avg_nxt       = avg_r;
    primed_nxt    = primed_r;
    s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
    out_valid_nxt = out_take ? s1_valid_r : out_valid_r;
    out_value_nxt = out_value_r;
    out_ok_nxt    = out_ok_r;

    if (s1_move) begin
      if (s1_rdy_r) begin
        primed_nxt = 1'b1;
        avg_nxt    = primed_r ? avg_upd : {med, {FW{1'b0}}};
      end
      out_value_nxt = avg_nxt[VW-1:FW];
      out_ok_nxt    = s1_rdy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      alpha_r     <= mcf_pkg::ALPHA_RESET;
      avg_r       <= '0;
      primed_r    <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      alpha_r     <= alpha_nxt;
      avg_r       <= avg_nxt;
      primed_r    <= primed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_a_r   <= in_sample_a;
      s1_b_r   <= in_sample_b;
      s1_c_r   <= in_sample_c;
      s1_rdy_r <= in_converter_ready;
    end
    out_value_r <= out_value_nxt;
    out_ok_r    <= out_ok_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_value_r;
  assign out_sensor_ok      = out_ok_r;

endmodule
`default_nettype wire

// ----- hdl/mcf_checker.sv -----
`default_nettype none
`include "median3_ema_loadcell_filter_defines.svh"
module mcf_checker (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire [mcf_pkg::SAMPLE_W-1:0] out_filtered_value,
  input wire                         out_sensor_ok
);

  logic                     seen_r;
  logic                     ok_seen_r;
  mcf_pkg::sample_t         last_val_r;

  // last delivered value, and whether any ok result went out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= 1'b0;
      ok_seen_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_r    <= 1'b1;
      ok_seen_r <= ok_seen_r || out_sensor_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      last_val_r <= out_filtered_value;
    end
  end

  `MCF_ASSERT_ANY(a_reset_clears, !rst_n |=> !out_valid, "result valid right after reset")
  `MCF_ASSERT_CLK(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_filtered_value) && $stable(out_sensor_ok), "stalled result changed")
  `MCF_ASSERT_CLK(a_not_ok_holds, out_valid && !out_sensor_ok && seen_r |-> out_filtered_value == last_val_r, "average moved on a not-ok transaction")
  `MCF_ASSERT_CLK(a_unprimed_zero, out_valid && !out_sensor_ok && !ok_seen_r |-> out_filtered_value == '0, "average nonzero before first ok sample")

endmodule

bind median3_ema_loadcell_filter mcf_checker u_mcf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_filtered_value (out_filtered_value),
  .out_sensor_ok      (out_sensor_ok)
);
`default_nettype wire

// ----- tb/tb_median3_ema_loadcell_filter.sv -----
`default_nettype none
module tb_median3_ema_loadcell_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 8;

  typedef logic [mcf_pkg::ALPHA_W-1:0] alpha_t;

  typedef struct packed {
    mcf_pkg::sample_t filtered;
    logic             ok;
  } ema_out_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  alpha_t           cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  mcf_pkg::sample_t in_sample_a = '0;
  mcf_pkg::sample_t in_sample_b = '0;
  mcf_pkg::sample_t in_sample_c = '0;
  logic             in_converter_ready = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  mcf_pkg::sample_t out_filtered_value;
  logic             out_sensor_ok;

  // filter state tracked alongside the DUT
  mcf_pkg::avg_t ema_avg = '0;
  logic          ema_primed = 1'b0;
  alpha_t        ema_alpha = mcf_pkg::ALPHA_RESET;

  ema_out_t         ema_outputs[$];
  int               mismatches = 0;
  int               cycles = 0;
  int               idle_pct = 0;
  int               stall_pct = 0;
  mcf_pkg::sample_t drift_base = '0;

  median3_ema_loadcell_filter DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample_a        (in_sample_a),
    .in_sample_b        (in_sample_b),
    .in_sample_c        (in_sample_c),
    .in_converter_ready (in_converter_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_value (out_filtered_value),
    .out_sensor_ok      (out_sensor_ok)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // flipping the sign bit gives offset binary, whose unsigned order is the signed order
  function automatic mcf_pkg::sample_t offset_bin(mcf_pkg::sample_t s);
    return {~s[mcf_pkg::SAMPLE_W-1], s[mcf_pkg::SAMPLE_W-2:0]};
  endfunction

  function automatic mcf_pkg::sample_t mid_of_three(mcf_pkg::sample_t a, mcf_pkg::sample_t b,
                                                    mcf_pkg::sample_t c);
    mcf_pkg::sample_t lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) return lo;
    if (c >= hi) return hi;
    return c;
  endfunction

  task automatic ema_update(input mcf_pkg::sample_t a, input mcf_pkg::sample_t b,
                            input mcf_pkg::sample_t c, input logic rdy, output ema_out_t r);
    mcf_pkg::sample_t x;
    logic [63:0]      acc;
    if (rdy) begin
      x = mid_of_three(offset_bin(a), offset_bin(b), offset_bin(c));
      if (!ema_primed) begin
        ema_avg = {x, {mcf_pkg::FRAC_W{1'b0}}};
        ema_primed = 1'b1;
      end else begin
        acc = 64'(ema_alpha) * 64'({x, {mcf_pkg::FRAC_W{1'b0}}})
            + (64'd65536 - 64'(ema_alpha)) * 64'(ema_avg);
        ema_avg = acc[mcf_pkg::AVG_W+mcf_pkg::FRAC_W-1:mcf_pkg::FRAC_W];
      end
    end
    r.filtered = ema_avg[mcf_pkg::AVG_W-1:mcf_pkg::FRAC_W];
    r.ok = rdy;
  endtask

  // called at a rising edge; returns at the edge where the transaction is accepted
  task automatic send_item(input mcf_pkg::sample_t a, input mcf_pkg::sample_t b,
                           input mcf_pkg::sample_t c, input logic rdy);
    ema_out_t r;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_sample_a <= a;
    in_sample_b <= b;
    in_sample_c <= c;
    in_converter_ready <= rdy;
    do @(posedge clk); while (!in_ready);
    ema_update(a, b, c, rdy, r);
    ema_outputs.push_back(r);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ema_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_alpha(input alpha_t v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    ema_alpha = v;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : rx_check
    ema_out_t want;
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (ema_outputs.size() == 0) begin
        $error("result with no transaction pending: filtered_value=%0d sensor_ok=%0b",
               out_filtered_value, out_sensor_ok);
        mismatches++;
      end else begin
        want = ema_outputs.pop_front();
        if (out_filtered_value !== want.filtered) begin
          $error("filtered_value: expected %0d, got %0d", want.filtered, out_filtered_value);
          mismatches++;
        end
        if (out_sensor_ok !== want.ok) begin
          $error("sensor_ok: expected %0b, got %0b", want.ok, out_sensor_ok);
          mismatches++;
        end
      end
    end
  end

  localparam mcf_pkg::sample_t S_MIN = 24'h800000;
  localparam mcf_pkg::sample_t S_MAX = 24'h7FFFFF;

  // converter not ready before any valid sample: average reads zero
  task automatic test_unprimed_hold();
    send_item(24'h123456, 24'hFEDCBA, 24'h000001, 1'b0);
    send_item(S_MIN, S_MAX, 24'hFFFFFF, 1'b0);
  endtask

  task automatic test_median_select();
    send_item(S_MIN, S_MAX, 24'h000000, 1'b1);  // primes the average
    send_item(S_MAX, S_MAX, S_MAX, 1'b1);
    send_item(S_MIN, S_MIN, S_MIN, 1'b1);
    // all orderings of three distinct values
    send_item(24'd1, -24'sd5, 24'd100, 1'b1);
    send_item(24'd1, 24'd100, -24'sd5, 1'b1);
    send_item(-24'sd5, 24'd1, 24'd100, 1'b1);
    send_item(-24'sd5, 24'd100, 24'd1, 1'b1);
    send_item(24'd100, 24'd1, -24'sd5, 1'b1);
    send_item(24'd100, -24'sd5, 24'd1, 1'b1);
    // two equal samples
    send_item(24'd7, 24'd7, -24'sd3, 1'b1);
    send_item(-24'sd3, 24'd7, 24'd7, 1'b1);
    send_item(24'h555555, 24'hAAAAAA, 24'h555555, 1'b1);
    // not ready after priming: average held
    send_item(S_MAX, S_MAX, S_MAX, 1'b0);
    wait_results_drained();
  endtask

  task automatic test_alpha_extremes();
    write_alpha(16'hFFFF);
    send_item(S_MAX, S_MAX, S_MAX, 1'b1);
    send_item(S_MIN, S_MIN, S_MIN, 1'b1);
    send_item(S_MAX, S_MIN, S_MAX, 1'b1);
    wait_results_drained();
    write_alpha(16'd1);
    send_item(S_MIN, S_MIN, S_MIN, 1'b1);
    send_item(S_MAX, S_MAX, S_MAX, 1'b1);
    send_item(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b1);
    wait_results_drained();
    write_alpha(16'h8000);
  endtask

  function automatic mcf_pkg::sample_t pick_sample();
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) return mcf_pkg::sample_t'($urandom);
    if (sel < 50) begin
      case ($urandom_range(3))
        0: return S_MIN;
        1: return S_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return drift_base + mcf_pkg::sample_t'($urandom_range(511)) - mcf_pkg::sample_t'(256);
  endfunction

  task automatic run_random_phase(input int n, input int idle, input int stall,
                                  input alpha_t alpha);
    idle_pct = idle;
    stall_pct = stall;
    write_alpha(alpha);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && i % 110 == 0) begin
        wait_results_drained();
        write_alpha(alpha_t'($urandom_range(65535, 1)));
      end
      if ($urandom_range(99) < 10) drift_base = mcf_pkg::sample_t'($urandom);
      else drift_base = drift_base + mcf_pkg::sample_t'($urandom_range(4095))
                        - mcf_pkg::sample_t'(2048);
      send_item(pick_sample(), pick_sample(), pick_sample(), $urandom_range(99) < 85);
    end
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    run_random_phase(330, 0, 0, alpha_t'($urandom_range(65535, 1)));
    run_random_phase(330, 80, 0, 16'hFFFF);
    run_random_phase(330, 0, 80, 16'd1);
    run_random_phase(330, 29, 29, alpha_t'($urandom_range(65535, 1)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unprimed_hold();
    test_median_select();
    test_alpha_extremes();
    test_random_traffic();
    wait_results_drained();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/mcf_pkg.sv
hdl/median3_ema_loadcell_filter.sv
hdl/mcf_checker.sv
tb/tb_median3_ema_loadcell_filter.sv
